// File: rtl/core/tomsu_pkg.sv
// Shared types, constants and the line readiness rule for the tagged
// operand matching store. No dependencies.
`timescale 1ns / 1ps
package tomsu_pkg;

	localparam int IN_W  = 96;
	localparam int OUT_W = 80;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PORT1_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT2_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT3_EN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MUX_MODE = 2'd3;

	typedef enum logic [2:0] {ST_IDLE, ST_P1, ST_P2, ST_P3, ST_OUT} state_t;
	typedef enum logic [1:0] {PORT_NONE, PORT_1, PORT_2, PORT_3} port_t;

	typedef struct packed {
		logic  load;
		port_t port;
		logic  out_we;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctl_sts_t;

	function automatic logic line_ready(input logic e1, input logic e2, input logic e3,
		input logic mux, input logic f1, input logic f2, input logic f3, input logic b3);
		logic r;
		begin
			if (!e1 && !e2 && !e3) begin
				r = 1'b0;
			end else if (mux && e3 && (e1 || e2)) begin
				r = f3 && (b3 ? (e1 && f1) : (e2 && f2));
			end else begin
				r = (!e1 || f1) && (!e2 || f2) && (!e3 || f3);
			end
			return r;
		end
	endfunction

endpackage

// File: rtl/core/tomsu_ctrl.sv
// Sequencer for the matching store: accepts one transaction, steps the
// three ports through the datapath, then loads the result register.
// Depends on tomsu_pkg.
`timescale 1ns / 1ps
module tomsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tomsu_pkg::ctl_sts_t sts,
	output tomsu_pkg::ctl_cmd_t cmd
);
	tomsu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tomsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.port = tomsu_pkg::PORT_NONE;
		cmd.out_we = 1'b0;
		s_tready = 1'b0;
		unique case (state_q)
			tomsu_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = tomsu_pkg::ST_P1;
				end
			end
			tomsu_pkg::ST_P1: begin
				cmd.port = tomsu_pkg::PORT_1;
				state_d = tomsu_pkg::ST_P2;
			end
			tomsu_pkg::ST_P2: begin
				cmd.port = tomsu_pkg::PORT_2;
				state_d = tomsu_pkg::ST_P3;
			end
			tomsu_pkg::ST_P3: begin
				cmd.port = tomsu_pkg::PORT_3;
				state_d = tomsu_pkg::ST_OUT;
			end
			tomsu_pkg::ST_OUT: begin
				// hold until the result register can take the new result
				if (sts.out_free) begin
					cmd.out_we = 1'b1;
					state_d = tomsu_pkg::ST_IDLE;
				end
			end
			default: state_d = tomsu_pkg::ST_IDLE;
		endcase
	end
endmodule

// File: rtl/core/tomsu_dp.sv
// Datapath of the matching store: line table, ready queue, last-tag
// registers, configuration registers and result register.
// Depends on tomsu_pkg.
`timescale 1ns / 1ps
module tomsu_dp #(
	parameter int LINES = 8,
	parameter int TAG_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tomsu_pkg::ctl_cmd_t              cmd,
	output tomsu_pkg::ctl_sts_t              sts,
	input  logic [tomsu_pkg::IN_W-1:0]       s_tdata,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [tomsu_pkg::OUT_W-1:0]      m_tdata,
	input  logic                             cfg_we,
	input  logic [tomsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                             cfg_data
);
	localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int CW = $clog2(LINES + 1);
	localparam int DW = tomsu_pkg::DATA_W;

	logic en1_q, en2_q, en3_q, mux_q;

	logic [TAG_WIDTH-1:0] line_tag_q [LINES];
	logic [DW-1:0]        line_val1_q [LINES];
	logic [DW-1:0]        line_val2_q [LINES];
	logic [LINES-1:0]     full1_q, full2_q, full3_q, bool3_q, queued_q;
	logic [IW-1:0]        queue_q [LINES];
	logic [IW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [TAG_WIDTH-1:0] last_q [3];
	logic [2:0]           seen_q;
	logic [2:0]           ack_q;

	// item fields held for the port steps
	logic                 p1v_q, p2v_q, p3v_q, p3b_q;
	logic [DW-1:0]        p1d_q, p2d_q;
	logic [TAG_WIDTH-1:0] p1t_q, p2t_q, p3t_q;

	// current port step
	logic                 sel_v;
	logic [TAG_WIDTH-1:0] sel_t;
	logic [DW-1:0]        sel_d;
	logic [1:0]           pi;
	logic [LINES-1:0]     hitv, freev;
	logic [IW-1:0]        hit_idx, free_idx, idx;
	logic                 any_hit, slot_full, ok, f1n, f2n, f3n, b3n, enq;
	logic [IW-1:0]        tail;
	logic [IW:0]          tail_sum;
	logic                 do_rel;
	logic [IW-1:0]        head_line;

	always_comb begin
		sel_v = 1'b0;
		sel_t = '0;
		sel_d = '0;
		pi = 2'd0;
		case (cmd.port)
			tomsu_pkg::PORT_1: begin
				sel_v = p1v_q && en1_q; sel_t = p1t_q; sel_d = p1d_q; pi = 2'd0;
			end
			tomsu_pkg::PORT_2: begin
				sel_v = p2v_q && en2_q; sel_t = p2t_q; sel_d = p2d_q; pi = 2'd1;
			end
			tomsu_pkg::PORT_3: begin
				sel_v = p3v_q && en3_q; sel_t = p3t_q; sel_d = DW'(p3b_q); pi = 2'd2;
			end
			default: ;
		endcase
	end

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = 0; i < LINES; i++) begin
			hitv[i] = line_tag_q[i] == sel_t;
			freev[i] = line_tag_q[i] == '0;
		end
		for (int i = LINES - 1; i >= 0; i--) begin
			if (hitv[i]) hit_idx = IW'(i);
			if (freev[i]) free_idx = IW'(i);
		end
		any_hit = |hitv;
		idx = any_hit ? hit_idx : free_idx;
		case (pi)
			2'd0:    slot_full = full1_q[idx];
			2'd1:    slot_full = full2_q[idx];
			default: slot_full = full3_q[idx];
		endcase
		ok = sel_v && (sel_t != '0) && !(seen_q[pi] && last_q[pi] == sel_t)
			&& (any_hit ? !slot_full : |freev);
		f1n = full1_q[idx] || (pi == 2'd0);
		f2n = full2_q[idx] || (pi == 2'd1);
		f3n = full3_q[idx] || (pi == 2'd2);
		b3n = (pi == 2'd2) ? sel_d[0] : bool3_q[idx];
		enq = ok && !queued_q[idx] && (count_q < CW'(LINES))
			&& tomsu_pkg::line_ready(en1_q, en2_q, en3_q, mux_q, f1n, f2n, f3n, b3n);
		tail_sum = {1'b0, head_q} + (IW + 1)'(count_q);
		tail = (tail_sum >= (IW + 1)'(LINES)) ? IW'(tail_sum - (IW + 1)'(LINES))
			: tail_sum[IW-1:0];
	end

	assign head_line = queue_q[head_q];
	assign do_rel = cmd.load && s_tdata[0] && (count_q != '0);
	assign sts.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en1_q <= 1'b1;
			en2_q <= 1'b1;
			en3_q <= 1'b0;
			mux_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tomsu_pkg::CFG_PORT1_EN: en1_q <= cfg_data;
				tomsu_pkg::CFG_PORT2_EN: en2_q <= cfg_data;
				tomsu_pkg::CFG_PORT3_EN: en3_q <= cfg_data;
				tomsu_pkg::CFG_MUX_MODE: mux_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p1v_q <= s_tdata[1];
			p1d_q <= s_tdata[33:2];
			p1t_q <= TAG_WIDTH'(s_tdata[41:34]);
			p2v_q <= s_tdata[42];
			p2d_q <= s_tdata[74:43];
			p2t_q <= TAG_WIDTH'(s_tdata[82:75]);
			p3v_q <= s_tdata[83];
			p3b_q <= s_tdata[84];
			p3t_q <= TAG_WIDTH'(s_tdata[92:85]);
		end
		if (enq) queue_q[tail] <= idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				line_tag_q[i] <= '0;
				line_val1_q[i] <= '0;
				line_val2_q[i] <= '0;
			end
			full1_q <= '0;
			full2_q <= '0;
			full3_q <= '0;
			bool3_q <= '0;
			queued_q <= '0;
			head_q <= '0;
			count_q <= '0;
			for (int p = 0; p < 3; p++) last_q[p] <= '0;
			seen_q <= '0;
			ack_q <= '0;
		end else begin
			if (do_rel) begin
				// drop the oldest ready line
				line_tag_q[head_line] <= '0;
				line_val1_q[head_line] <= '0;
				line_val2_q[head_line] <= '0;
				full1_q[head_line] <= 1'b0;
				full2_q[head_line] <= 1'b0;
				full3_q[head_line] <= 1'b0;
				bool3_q[head_line] <= 1'b0;
				queued_q[head_line] <= 1'b0;
				head_q <= (head_q == IW'(LINES - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.port != tomsu_pkg::PORT_NONE) begin
				ack_q[pi] <= ok;
				if (ok) begin
					line_tag_q[idx] <= sel_t;
					case (pi)
						2'd0: begin
							full1_q[idx] <= 1'b1;
							line_val1_q[idx] <= sel_d;
						end
						2'd1: begin
							full2_q[idx] <= 1'b1;
							line_val2_q[idx] <= sel_d;
						end
						default: begin
							full3_q[idx] <= 1'b1;
							bool3_q[idx] <= sel_d[0];
						end
					endcase
					last_q[pi] <= sel_t;
					seen_q[pi] <= 1'b1;
				end
				if (enq) begin
					queued_q[idx] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_we) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_we) begin
			m_tdata[2:0] <= ack_q;
			if (count_q != '0) begin
				m_tdata[3]     <= 1'b1;
				m_tdata[11:4]  <= 8'(line_tag_q[head_line]);
				m_tdata[43:12] <= line_val1_q[head_line];
				m_tdata[44]    <= full1_q[head_line];
				m_tdata[76:45] <= line_val2_q[head_line];
				m_tdata[77]    <= full2_q[head_line];
				m_tdata[78]    <= bool3_q[head_line];
				m_tdata[79]    <= full3_q[head_line];
			end else begin
				m_tdata[79:3] <= '0;
			end
		end
	end
endmodule

// File: rtl/core/tagged_operand_matching_store_unit.sv
// Top level of the tagged operand matching store.
// Depends on tomsu_pkg, tomsu_ctrl and tomsu_dp.
//
// Usage: each slave-side transaction carries one step (a release request
// and up to three tagged tokens); each produces exactly one master-side
// transaction holding the three acks and the oldest ready line.
// The release is applied in the accept cycle, then ports one, two and
// three in turn each do a tag search and line update against the
// table, and a final step loads the result register.
// A new transaction is taken only once the current one has loaded its
// result, as the accept step, the one shared search/update unit used
// once per port, and the result load step run one after another.
// A stalled receiver holds the result in the output register; the next
// transaction is still taken and processed, and waits only at its final
// step until the register frees.
// Reset clears the line table, the ready queue count, the last-tag marks
// and restores the configuration defaults (ports one and two enabled).
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 port1_enable, 1 port2_enable, 2 port3_enable, 3 mux_mode); write
// only while idle.
`timescale 1ns / 1ps
module tagged_operand_matching_store_unit #(
	parameter int LINES = 8,
	parameter int TAG_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// release_ready, p1_valid, p1_data, p1_tag, p2_valid, p2_data, p2_tag,
	// p3_valid, p3_bit, p3_tag, zero fill
	input  logic [tomsu_pkg::IN_W-1:0]       s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// ack1, ack2, ack3, ready_valid, ready_tag, ready_data1, ready_has1,
	// ready_data2, ready_has2, ready_bit3, ready_has3
	output logic [tomsu_pkg::OUT_W-1:0]      m_tdata,
	input  logic                             cfg_we,
	input  logic [tomsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                             cfg_data
);
	tomsu_pkg::ctl_cmd_t cmd;
	tomsu_pkg::ctl_sts_t sts;

	tomsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tomsu_dp #(
		.LINES     (LINES),
		.TAG_WIDTH (TAG_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule
